// ----- rtl/tfd_pkg.sv -----
// types, constants and register indexes shared by the target-follow drive controller
// no dependencies; compiled before the interfaces and modules
`default_nettype none

package tfd_pkg;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic signed [7:0] MIN_RSSI_DBM = -8'sd90;
  localparam logic [15:0]       NEAR_STOP_CM = 16'd50;

  localparam logic [15:0] RST_START_DISTANCE_CM  = 16'd100;
  localparam logic [7:0]  RST_DISTANCE_GAIN      = 8'd4;
  localparam logic [9:0]  RST_MAX_SPEED          = 10'd600;
  localparam logic [7:0]  RST_ANGLE_DEADBAND_DEG = 8'd10;
  localparam logic [7:0]  RST_TURN_GAIN          = 8'd5;
  localparam logic [9:0]  RST_MAX_TURN           = 10'd300;
  localparam logic [9:0]  RST_SPEED_STEP         = 10'd50;
  localparam logic [15:0] RST_LOST_TIMEOUT_MS    = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_DISTANCE_CM  = 4'd0,
    REG_DISTANCE_GAIN      = 4'd1,
    REG_MAX_SPEED          = 4'd2,
    REG_ANGLE_DEADBAND_DEG = 4'd3,
    REG_TURN_GAIN          = 4'd4,
    REG_MAX_TURN           = 4'd5,
    REG_SPEED_STEP         = 4'd6,
    REG_LOST_TIMEOUT_MS    = 4'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_NO_TARGET = 3'd0,
    ST_TIMEOUT   = 3'd1,
    ST_WEAK      = 3'd2,
    ST_TOO_CLOSE = 3'd3,
    ST_HOLD      = 3'd4,
    ST_TRACK     = 3'd5
  } follow_status_t;

  typedef struct packed {
    logic [15:0] start_distance_cm;
    logic [7:0]  distance_gain;
    logic [9:0]  max_speed;
    logic [7:0]  angle_deadband_deg;
    logic [7:0]  turn_gain;
    logic [9:0]  max_turn;
    logic [9:0]  speed_step;
    logic [15:0] lost_timeout_ms;
  } cfg_regs_t;

  typedef struct packed {
    logic              mode_active;
    logic              target_valid;
    logic [15:0]       age_ms;
    logic signed [7:0] signal_level;
    logic [15:0]       range_cm;
    logic signed [8:0] bearing;
  } tick_t;

  // left/right are also the next wheel state (zero on stop and when inactive)
  typedef struct packed {
    logic               emit;
    logic               stop_cmd;
    logic signed [10:0] left_speed;
    logic signed [10:0] right_speed;
    follow_status_t     follow_status;
  } drive_res_t;

endpackage

`default_nettype wire

// ----- rtl/tfd_tick_if.sv -----
// tick item channel: follow-mode flag and latest ranging report
// depends on nothing
`default_nettype none

interface tfd_tick_if;
  logic              valid;
  logic              ready;
  logic              mode_active;
  logic              target_valid;
  logic [15:0]       age_ms;
  logic signed [7:0] signal_level;
  logic [15:0]       range_cm;
  logic signed [8:0] bearing;

  modport source (
    output valid, mode_active, target_valid, age_ms, signal_level, range_cm, bearing,
    input  ready
  );
  modport sink (
    input  valid, mode_active, target_valid, age_ms, signal_level, range_cm, bearing,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/tfd_cmd_if.sv -----
// drive command result channel
// depends on nothing
`default_nettype none

interface tfd_cmd_if;
  logic               valid;
  logic               ready;
  logic               stop_cmd;
  logic signed [10:0] left_speed;
  logic signed [10:0] right_speed;
  logic [2:0]         follow_status;

  modport source (
    output valid, stop_cmd, left_speed, right_speed, follow_status,
    input  ready
  );
  modport sink (
    input  valid, stop_cmd, left_speed, right_speed, follow_status,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/tfd_cfg_if.sv -----
// configuration write channel: register index and write data
// uses tfd_pkg for field widths
`default_nettype none

interface tfd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tfd_pkg::CFG_IDX_W-1:0]    index;
  logic [tfd_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/tfd_cfg.sv -----
// configuration register file of the drive controller
// uses tfd_pkg and tfd_cfg_if
`default_nettype none

module tfd_cfg (
  input  wire logic          clk,
  input  wire logic          rst,
  tfd_cfg_if.sink            wr,
  output tfd_pkg::cfg_regs_t regs
);

  assign wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.start_distance_cm  <= tfd_pkg::RST_START_DISTANCE_CM;
      regs.distance_gain      <= tfd_pkg::RST_DISTANCE_GAIN;
      regs.max_speed          <= tfd_pkg::RST_MAX_SPEED;
      regs.angle_deadband_deg <= tfd_pkg::RST_ANGLE_DEADBAND_DEG;
      regs.turn_gain          <= tfd_pkg::RST_TURN_GAIN;
      regs.max_turn           <= tfd_pkg::RST_MAX_TURN;
      regs.speed_step         <= tfd_pkg::RST_SPEED_STEP;
      regs.lost_timeout_ms    <= tfd_pkg::RST_LOST_TIMEOUT_MS;
    end else if (wr.valid) begin
      unique case (wr.index)
        tfd_pkg::REG_START_DISTANCE_CM:  regs.start_distance_cm  <= wr.data;
        tfd_pkg::REG_DISTANCE_GAIN:      regs.distance_gain      <= wr.data[7:0];
        tfd_pkg::REG_MAX_SPEED:          regs.max_speed          <= wr.data[9:0];
        tfd_pkg::REG_ANGLE_DEADBAND_DEG: regs.angle_deadband_deg <= wr.data[7:0];
        tfd_pkg::REG_TURN_GAIN:          regs.turn_gain          <= wr.data[7:0];
        tfd_pkg::REG_MAX_TURN:           regs.max_turn           <= wr.data[9:0];
        tfd_pkg::REG_SPEED_STEP:         regs.speed_step         <= wr.data[9:0];
        tfd_pkg::REG_LOST_TIMEOUT_MS:    regs.lost_timeout_ms    <= wr.data;
        default: begin
          // index beyond the register list: ignored
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tfd_calc.sv -----
// drive law of one tick: report checks, base and turn terms, clamping and slew
// uses tfd_pkg; purely combinational
`default_nettype none

module tfd_calc (
  input  wire tfd_pkg::tick_t     tick,
  input  wire tfd_pkg::cfg_regs_t regs,
  input  wire logic signed [10:0] left_now,
  input  wire logic signed [10:0] right_now,
  output tfd_pkg::drive_res_t   res
);

  logic [15:0]        dist_diff;
  logic [23:0]        speed_prod;
  logic [9:0]         base;
  logic [8:0]         ang_mag;
  logic signed [17:0] turn_prod;
  logic signed [17:0] turn_lim;
  logic signed [10:0] turn;
  logic signed [11:0] sum_l;
  logic signed [11:0] sum_r;
  logic signed [11:0] spd_lim;
  logic signed [11:0] tgt_l;
  logic signed [11:0] tgt_r;
  logic signed [12:0] step;
  logic signed [12:0] d_l;
  logic signed [12:0] d_r;
  logic signed [12:0] new_l;
  logic signed [12:0] new_r;
  logic               hold;

  // base speed from distance beyond the start distance
  assign dist_diff  = tick.range_cm - regs.start_distance_cm;
  assign speed_prod = dist_diff * regs.distance_gain;

  always_comb begin
    if (tick.range_cm <= regs.start_distance_cm) begin
      base = '0;
    end else if (speed_prod > {14'd0, regs.max_speed}) begin
      base = regs.max_speed;
    end else begin
      base = speed_prod[9:0];
    end
  end

  // turn term from bearing outside the deadband
  assign ang_mag   = tick.bearing[8] ? 9'(-tick.bearing) : tick.bearing;
  assign turn_prod = $signed(tick.bearing) * $signed({1'b0, regs.turn_gain});
  assign turn_lim  = $signed({8'd0, regs.max_turn});

  always_comb begin
    if (ang_mag <= {1'b0, regs.angle_deadband_deg}) begin
      turn = '0;
    end else if (turn_prod > turn_lim) begin
      turn = 11'(turn_lim);
    end else if (turn_prod < -turn_lim) begin
      turn = 11'(-turn_lim);
    end else begin
      turn = 11'(turn_prod);
    end
  end

  assign hold    = (base == '0) && (turn == '0);
  assign sum_l   = $signed({2'b00, base}) + 12'(turn);
  assign sum_r   = $signed({2'b00, base}) - 12'(turn);
  assign spd_lim = $signed({2'b00, regs.max_speed});

  always_comb begin
    if (sum_l > spd_lim) begin
      tgt_l = spd_lim;
    end else if (sum_l < -spd_lim) begin
      tgt_l = -spd_lim;
    end else begin
      tgt_l = sum_l;
    end
    if (sum_r > spd_lim) begin
      tgt_r = spd_lim;
    end else if (sum_r < -spd_lim) begin
      tgt_r = -spd_lim;
    end else begin
      tgt_r = sum_r;
    end
  end

  // slew limit against the current wheel speeds
  assign step = $signed({3'b000, regs.speed_step});
  assign d_l  = 13'(tgt_l) - 13'(left_now);
  assign d_r  = 13'(tgt_r) - 13'(right_now);

  always_comb begin
    if (d_l > step) begin
      new_l = 13'(left_now) + step;
    end else if (d_l < -step) begin
      new_l = 13'(left_now) - step;
    end else begin
      new_l = 13'(tgt_l);
    end
    if (d_r > step) begin
      new_r = 13'(right_now) + step;
    end else if (d_r < -step) begin
      new_r = 13'(right_now) - step;
    end else begin
      new_r = 13'(tgt_r);
    end
  end

  always_comb begin
    res.emit          = tick.mode_active;
    res.stop_cmd      = 1'b1;
    res.left_speed    = '0;
    res.right_speed   = '0;
    res.follow_status = tfd_pkg::ST_HOLD;
    if (!tick.target_valid) begin
      res.follow_status = tfd_pkg::ST_NO_TARGET;
    end else if (tick.age_ms > regs.lost_timeout_ms) begin
      res.follow_status = tfd_pkg::ST_TIMEOUT;
    end else if (tick.signal_level < tfd_pkg::MIN_RSSI_DBM) begin
      res.follow_status = tfd_pkg::ST_WEAK;
    end else if (tick.range_cm < tfd_pkg::NEAR_STOP_CM) begin
      res.follow_status = tfd_pkg::ST_TOO_CLOSE;
    end else if (hold) begin
      res.follow_status = tfd_pkg::ST_HOLD;
    end else begin
      res.stop_cmd      = 1'b0;
      res.left_speed    = 11'(new_l);
      res.right_speed   = 11'(new_r);
      res.follow_status = tfd_pkg::ST_TRACK;
    end
    // inactive tick: wheels cleared, nothing emitted
    if (!tick.mode_active) begin
      res.stop_cmd    = 1'b1;
      res.left_speed  = '0;
      res.right_speed = '0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/target_follow_drive_controller_top.sv -----
// a tick accepted into the tick register has its command in the result register
// once it advances; one tick accepted per cycle, sustained, while the output is free
// the rate is set by the single compute stage between tick and result registers,
// which also updates the wheel speed state; inactive ticks pass even when the output stalls
// reset: registers to their defaults, wheel speeds to zero, tick and result stages empty
// top level of the target-follow drive controller; uses tfd_pkg, the interfaces,
// tfd_cfg and tfd_calc
`default_nettype none

module target_follow_drive_controller_top (
  input  wire logic clk,
  input  wire logic rst,
  tfd_tick_if.sink  tick,
  tfd_cmd_if.source cmd,
  tfd_cfg_if.sink   cfg
);

  tfd_pkg::cfg_regs_t  regs;
  tfd_pkg::tick_t      tick_q;
  tfd_pkg::drive_res_t res;
  logic                tick_vld;
  logic                cmd_vld;
  logic signed [10:0]  left_now;
  logic signed [10:0]  right_now;
  logic                out_free;
  logic                adv;

  tfd_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .wr   (cfg),
    .regs (regs)
  );

  tfd_calc u_calc (
    .tick      (tick_q),
    .regs      (regs),
    .left_now  (left_now),
    .right_now (right_now),
    .res       (res)
  );

  assign out_free   = !cmd_vld || cmd.ready;
  // an inactive tick produces no item, so it need not wait for the output
  assign adv        = tick_vld && (!tick_q.mode_active || out_free);
  assign tick.ready = !tick_vld || adv;
  assign cmd.valid  = cmd_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_vld <= 1'b0;
    end else if (tick.ready) begin
      tick_vld <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      tick_q.mode_active  <= tick.mode_active;
      tick_q.target_valid <= tick.target_valid;
      tick_q.age_ms       <= tick.age_ms;
      tick_q.signal_level <= tick.signal_level;
      tick_q.range_cm     <= tick.range_cm;
      tick_q.bearing      <= tick.bearing;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_now  <= '0;
      right_now <= '0;
    end else if (adv) begin
      left_now  <= res.left_speed;
      right_now <= res.right_speed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_vld <= 1'b0;
    end else if (adv && res.emit) begin
      cmd_vld <= 1'b1;
    end else if (cmd.ready) begin
      cmd_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.emit) begin
      cmd.stop_cmd      <= res.stop_cmd;
      cmd.left_speed    <= res.left_speed;
      cmd.right_speed   <= res.right_speed;
      cmd.follow_status <= res.follow_status;
    end
  end

`ifndef SYNTHESIS
  logic signed [11:0] left_delta;
  logic signed [11:0] right_delta;
  logic signed [11:0] step_lim;

  assign left_delta  = 12'(res.left_speed) - 12'(left_now);
  assign right_delta = 12'(res.right_speed) - 12'(right_now);
  assign step_lim    = $signed({2'b00, regs.speed_step});

  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.stop_cmd |-> (cmd.left_speed == '0) && (cmd.right_speed == '0))
    else $error("stop command with non-zero wheel speed");

  a_inactive_clears: assert property (@(posedge clk) disable iff (rst)
    adv && !tick_q.mode_active |=> (left_now == '0) && (right_now == '0))
    else $error("inactive tick left wheel state set");

  a_slew_bound: assert property (@(posedge clk) disable iff (rst)
    adv && tick_q.mode_active && !res.stop_cmd |->
      (left_delta <= step_lim) && (left_delta >= -step_lim) &&
      (right_delta <= step_lim) && (right_delta >= -step_lim))
    else $error("wheel speed change beyond speed step");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !tick_vld |-> tick.ready)
    else $error("tick stage empty but not ready");
`endif

endmodule

`default_nettype wire
